FILE: rtl/circular_bucket_priority_queue_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the circular bucket priority queue
// Shared property shapes used by the top-level checks.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_BUCKET_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define CIRCULAR_BUCKET_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CBPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CBPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cbpq_pkg.sv
// ----------------------------------------------------------------------------
// cbpq_pkg
// Types and constants shared by the bucket queue controller and datapath.
// ----------------------------------------------------------------------------
package cbpq_pkg;

  localparam int OP_W   = 3;
  localparam int ELEM_W = 12;
  localparam int BKT_W  = 8;
  localparam int CFG_W  = 9;

  // Operation codes carried by a command beat.
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_POP     = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd2;
  localparam logic [OP_W-1:0] OP_MOVE    = 3'd3;
  localparam logic [OP_W-1:0] OP_ISEMPTY = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

  // Datapath micro-operations issued by the controller.
  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_ACCEPT,
    UOP_INS_RD,
    UOP_INS_WR,
    UOP_INS_FIN,
    UOP_REM_WR,
    UOP_SCAN_CHK,
    UOP_POP_WR,
    UOP_CLR
  } cbpq_uop_t;

  // Status returned by the datapath.
  typedef struct packed {
    logic ins_ok;
    logic rem_ok;
    logic mov_ok;
    logic head_valid;
    logic scan_last;
    logic clr_last;
  } cbpq_status_t;

endpackage

FILE: rtl/circular_bucket_priority_queue_top.sv
// ----------------------------------------------------------------------------
// circular_bucket_priority_queue_top
// Circular bucket priority queue with FIFO buckets kept as linked lists.
// ----------------------------------------------------------------------------
// A command beat (operation, elem, bucket, to_bucket) is taken on a rising
// edge where start is high and busy is low. Every command gives exactly one
// result beat: done is high for one cycle with popped_elem, found and
// is_empty, and the receiver cannot stall it. Those ports are only
// meaningful while done is high.
// The result is written in the last busy cycle of a command; done shows in
// the next cycle, when busy is already low, so that cycle can take the next
// command. Unused codes and rejected arguments answer from idle at once. Pop
// and is-empty scan from the current bucket past the empty buckets (below
// buckets_in_use) to a non-empty one; on an empty queue they scan all
// buckets_in_use buckets. The link memories have one read and one write
// port each, so each list update reads first and then writes, and the scan
// tests one bucket head per cycle.
// After reset the block sweeps all four memories to null, one entry per
// cycle over max(NUM_BUCKETS, NUM_ELEMS) entries, with busy high; clear reuses
// the same sweep. buckets_in_use is written through cfg_we/cfg_wdata at any
// time, but must only change while the queue is idle.
// ----------------------------------------------------------------------------
module circular_bucket_priority_queue_top #(
  parameter int NUM_BUCKETS = 256,
  parameter int NUM_ELEMS   = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [cbpq_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        start,
  output logic                        busy,
  input  logic [cbpq_pkg::OP_W-1:0]   operation,
  input  logic [cbpq_pkg::ELEM_W-1:0] elem,
  input  logic [cbpq_pkg::BKT_W-1:0]  bucket,
  input  logic [cbpq_pkg::BKT_W-1:0]  to_bucket,
  output logic                        done,
  output logic [cbpq_pkg::ELEM_W-1:0] popped_elem,
  output logic                        found,
  output logic                        is_empty
);
  import cbpq_pkg::*;

  `include "circular_bucket_priority_queue_top_assert.svh"

  // Micro-operation from the controller and status back from the datapath.
  cbpq_uop_t    uop;
  cbpq_status_t status;

  cbpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .status    (status),
    .uop       (uop),
    .busy      (busy),
    .done      (done)
  );

  // The datapath holds the bucket head/tail tables, the per-element link
  // tables, the scan pointer and the result registers.
  cbpq_dp #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .NUM_ELEMS   (NUM_ELEMS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .uop         (uop),
    .operation   (operation),
    .elem        (elem),
    .bucket      (bucket),
    .to_bucket   (to_bucket),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .status      (status),
    .popped_elem (popped_elem),
    .found       (found),
    .is_empty    (is_empty)
  );

  // A result beat is written as the controller returns to idle.
  `CBPQ_ASSERT_NOW(a_done_idle, done, !busy, "result beat while busy")

  // found and is_empty are never both set in a result beat.
  `CBPQ_ASSERT_NOW(a_flags_excl, done, !(found && is_empty), "found and is_empty")

  // Only a successful pop carries an element.
  `CBPQ_ASSERT_NOW(a_elem_zero, done && !found, popped_elem == '0, "stray element")

  // An accepted command either starts work or answers at once.
  `CBPQ_ASSERT_NEXT(a_accept, start && !busy, busy || done, "command dropped")

endmodule

FILE: rtl/cbpq_dp.sv
// ----------------------------------------------------------------------------
// cbpq_dp
// Datapath: bucket and link memories, scan pointer, result registers.
// ----------------------------------------------------------------------------
module cbpq_dp #(
  parameter int NUM_BUCKETS = 256,
  parameter int NUM_ELEMS   = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cbpq_pkg::cbpq_uop_t         uop,
  input  logic [cbpq_pkg::OP_W-1:0]   operation,
  input  logic [cbpq_pkg::ELEM_W-1:0] elem,
  input  logic [cbpq_pkg::BKT_W-1:0]  bucket,
  input  logic [cbpq_pkg::BKT_W-1:0]  to_bucket,
  input  logic                        cfg_we,
  input  logic [cbpq_pkg::CFG_W-1:0]  cfg_wdata,
  output cbpq_pkg::cbpq_status_t      status,
  output logic [cbpq_pkg::ELEM_W-1:0] popped_elem,
  output logic                        found,
  output logic                        is_empty
);
  import cbpq_pkg::*;

  localparam int EAW      = $clog2(NUM_ELEMS);
  localparam int LW       = $clog2(NUM_ELEMS + 1);
  localparam int BAW      = $clog2(NUM_BUCKETS);
  localparam int NBW      = $clog2(NUM_BUCKETS + 1);
  localparam int SWEEP    = (NUM_BUCKETS > NUM_ELEMS) ? NUM_BUCKETS : NUM_ELEMS;
  localparam int SW       = $clog2(SWEEP);
  localparam int NB_RESET = (NUM_BUCKETS < 256) ? NUM_BUCKETS : 256;
  localparam logic [LW-1:0] NULL_LINK = LW'(NUM_ELEMS);

  logic [LW-1:0] head_mem [NUM_BUCKETS];
  logic [LW-1:0] tail_mem [NUM_BUCKETS];
  logic [LW-1:0] next_mem [NUM_ELEMS];
  logic [LW-1:0] prev_mem [NUM_ELEMS];

  logic           head_we, tail_we, next_we, prev_we;
  logic           head_re, tail_re, next_re, prev_re;
  logic [BAW-1:0] head_wa, tail_wa, head_ra, tail_ra;
  logic [EAW-1:0] next_wa, prev_wa, next_ra, prev_ra;
  logic [LW-1:0]  head_wd, tail_wd, next_wd, prev_wd;
  logic [LW-1:0]  head_rd, tail_rd, next_rd, prev_rd;

  logic [NBW-1:0]    nb;
  logic [BAW-1:0]    cur;
  logic [NBW-1:0]    cnt;
  logic [SW-1:0]     sweep;
  logic [ELEM_W-1:0] e_r;
  logic [BAW-1:0]    rb_r;
  logic [BAW-1:0]    ib_r;
  logic [OP_W-1:0]   op_r;
  logic [LW-1:0]     h_r;

  logic [BAW:0]   cur_inc;
  logic [BAW-1:0] cur_adv;
  logic [BAW-1:0] cur_wrap;
  logic [LW-1:0]  e_link;
  logic [EAW-1:0] e_addr;
  logic           head_valid;
  logic           scan_last;
  logic           clr_last;

  assign cur_inc    = {1'b0, cur} + 1'b1;
  assign cur_adv    = (cur_inc == nb) ? '0 : cur_inc[BAW-1:0];
  assign cur_wrap   = ({1'b0, cur} >= nb) ? '0 : cur;
  assign e_link     = LW'(e_r);
  assign e_addr     = EAW'(e_r);
  assign head_valid = (head_rd != NULL_LINK);
  assign scan_last  = (cnt == nb - 1'b1);
  assign clr_last   = (sweep == SW'(SWEEP - 1));

  assign status.ins_ok     = (elem < NUM_ELEMS) && (bucket < nb);
  assign status.rem_ok     = (elem < NUM_ELEMS) && (bucket < NUM_BUCKETS);
  assign status.mov_ok     = (elem < NUM_ELEMS) && (bucket < NUM_BUCKETS) &&
                             (to_bucket < nb);
  assign status.head_valid = head_valid;
  assign status.scan_last  = scan_last;
  assign status.clr_last   = clr_last;

  // Memory port control for each micro-operation.
  always_comb begin
    head_we = 1'b0; tail_we = 1'b0; next_we = 1'b0; prev_we = 1'b0;
    head_re = 1'b0; tail_re = 1'b0; next_re = 1'b0; prev_re = 1'b0;
    head_wa = '0; tail_wa = '0; head_ra = '0; tail_ra = '0;
    next_wa = '0; prev_wa = '0; next_ra = '0; prev_ra = '0;
    head_wd = NULL_LINK; tail_wd = NULL_LINK;
    next_wd = NULL_LINK; prev_wd = NULL_LINK;
    case (uop)
      UOP_ACCEPT: begin
        if (operation inside {OP_POP, OP_ISEMPTY}) begin
          head_re = 1'b1;
          head_ra = cur_wrap;
        end else begin
          head_re = 1'b1;
          head_ra = BAW'(bucket);
          tail_re = 1'b1;
          tail_ra = BAW'(bucket);
          prev_re = 1'b1;
          prev_ra = EAW'(elem);
          next_re = 1'b1;
          next_ra = EAW'(elem);
        end
      end
      UOP_INS_RD: begin
        head_re = 1'b1;
        head_ra = ib_r;
        tail_re = 1'b1;
        tail_ra = ib_r;
      end
      UOP_INS_WR: begin
        tail_we = 1'b1;
        tail_wa = ib_r;
        tail_wd = e_link;
        prev_we = 1'b1;
        prev_wa = e_addr;
        if (!head_valid || tail_rd == NULL_LINK) begin
          head_we = 1'b1;
          head_wa = ib_r;
          head_wd = e_link;
          prev_wd = NULL_LINK;
        end else begin
          next_we = 1'b1;
          next_wa = EAW'(tail_rd);
          next_wd = e_link;
          prev_wd = tail_rd;
        end
      end
      UOP_INS_FIN: begin
        next_we = 1'b1;
        next_wa = e_addr;
        next_wd = NULL_LINK;
      end
      UOP_REM_WR: begin
        if (head_rd == e_link) begin
          head_we = 1'b1;
          head_wa = rb_r;
          head_wd = next_rd;
          if (next_rd == NULL_LINK) begin
            tail_we = 1'b1;
            tail_wa = rb_r;
            tail_wd = NULL_LINK;
          end else begin
            prev_we = 1'b1;
            prev_wa = EAW'(next_rd);
            prev_wd = NULL_LINK;
          end
        end else if (prev_rd != NULL_LINK) begin
          next_we = 1'b1;
          next_wa = EAW'(prev_rd);
          next_wd = next_rd;
          if (next_rd == NULL_LINK) begin
            tail_we = 1'b1;
            tail_wa = rb_r;
            tail_wd = prev_rd;
          end else begin
            prev_we = 1'b1;
            prev_wa = EAW'(next_rd);
            prev_wd = prev_rd;
          end
        end
      end
      UOP_SCAN_CHK: begin
        if (head_valid) begin
          next_re = 1'b1;
          next_ra = EAW'(head_rd);
        end else begin
          head_re = 1'b1;
          head_ra = cur_adv;
        end
      end
      UOP_POP_WR: begin
        head_we = 1'b1;
        head_wa = cur;
        if (next_rd == NULL_LINK) begin
          head_wd = NULL_LINK;
          tail_we = 1'b1;
          tail_wa = cur;
          tail_wd = NULL_LINK;
        end else begin
          head_wd = next_rd;
          prev_we = 1'b1;
          prev_wa = EAW'(next_rd);
          prev_wd = NULL_LINK;
        end
      end
      UOP_CLR: begin
        head_we = (sweep < NUM_BUCKETS);
        head_wa = BAW'(sweep);
        tail_we = (sweep < NUM_BUCKETS);
        tail_wa = BAW'(sweep);
        next_we = (sweep < NUM_ELEMS);
        next_wa = EAW'(sweep);
        prev_we = (sweep < NUM_ELEMS);
        prev_wa = EAW'(sweep);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (head_re) head_rd <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    if (tail_re) tail_rd <= tail_mem[tail_ra];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (next_re) next_rd <= next_mem[next_ra];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (prev_re) prev_rd <= prev_mem[prev_ra];
  end

  // Control registers: bucket count, scan pointer, clearing sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      nb    <= NBW'(NB_RESET);
      cur   <= '0;
      cnt   <= '0;
      sweep <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_wdata == '0) begin
          nb <= NBW'(1);
        end else if (cfg_wdata > NUM_BUCKETS) begin
          nb <= NBW'(NUM_BUCKETS);
        end else begin
          nb <= NBW'(cfg_wdata);
        end
      end
      case (uop)
        UOP_ACCEPT: begin
          if (operation inside {OP_POP, OP_ISEMPTY}) begin
            cur <= cur_wrap;
            cnt <= '0;
          end
        end
        UOP_SCAN_CHK: begin
          if (!head_valid) begin
            cur <= cur_adv;
            cnt <= cnt + 1'b1;
          end
        end
        UOP_CLR: begin
          cur   <= '0;
          sweep <= clr_last ? '0 : sweep + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk) begin
    case (uop)
      UOP_ACCEPT: begin
        e_r         <= elem;
        rb_r        <= BAW'(bucket);
        ib_r        <= (operation == OP_MOVE) ? BAW'(to_bucket) : BAW'(bucket);
        op_r        <= operation;
        popped_elem <= '0;
        found       <= 1'b0;
        is_empty    <= 1'b0;
      end
      UOP_SCAN_CHK: begin
        if (head_valid) begin
          h_r <= head_rd;
        end else if (scan_last && op_r == OP_ISEMPTY) begin
          is_empty <= 1'b1;
        end
      end
      UOP_POP_WR: begin
        popped_elem <= ELEM_W'(h_r);
        found       <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/cbpq_ctrl.sv
// ----------------------------------------------------------------------------
// cbpq_ctrl
// Controller: sequences each command through datapath micro-operations.
// ----------------------------------------------------------------------------
module cbpq_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [cbpq_pkg::OP_W-1:0] operation,
  input  cbpq_pkg::cbpq_status_t    status,
  output cbpq_pkg::cbpq_uop_t       uop,
  output logic                      busy,
  output logic                      done
);
  import cbpq_pkg::*;

  typedef enum logic [3:0] {
    ST_RST_CLR,
    ST_IDLE,
    ST_OP_CLR,
    ST_INS_RD,
    ST_INS_WR,
    ST_INS_FIN,
    ST_REM_WR,
    ST_SCAN,
    ST_POP_WR
  } state_t;

  state_t state;
  logic   move_r;
  logic   pop_r;

  assign busy = (state != ST_IDLE);

  always_comb begin
    case (state)
      ST_IDLE:    uop = start ? UOP_ACCEPT : UOP_NOP;
      ST_RST_CLR: uop = UOP_CLR;
      ST_OP_CLR:  uop = UOP_CLR;
      ST_INS_RD:  uop = UOP_INS_RD;
      ST_INS_WR:  uop = UOP_INS_WR;
      ST_INS_FIN: uop = UOP_INS_FIN;
      ST_REM_WR:  uop = UOP_REM_WR;
      ST_SCAN:    uop = UOP_SCAN_CHK;
      ST_POP_WR:  uop = UOP_POP_WR;
      default:    uop = UOP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_RST_CLR;
      done   <= 1'b0;
      move_r <= 1'b0;
      pop_r  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_RST_CLR: begin
          if (status.clr_last) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (start) begin
            move_r <= (operation == OP_MOVE);
            pop_r  <= (operation == OP_POP);
            case (operation)
              OP_INSERT: begin
                if (status.ins_ok) state <= ST_INS_WR;
                else done <= 1'b1;
              end
              OP_REMOVE: begin
                if (status.rem_ok) state <= ST_REM_WR;
                else done <= 1'b1;
              end
              OP_MOVE: begin
                if (status.mov_ok) state <= ST_REM_WR;
                else done <= 1'b1;
              end
              OP_POP, OP_ISEMPTY: state <= ST_SCAN;
              OP_CLEAR:           state <= ST_OP_CLR;
              default:            done  <= 1'b1;
            endcase
          end
        end
        ST_OP_CLR: begin
          if (status.clr_last) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        ST_INS_RD:  state <= ST_INS_WR;
        ST_INS_WR:  state <= ST_INS_FIN;
        ST_INS_FIN: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        ST_REM_WR: begin
          if (move_r) begin
            state <= ST_INS_RD;
          end else begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (status.head_valid) begin
            if (pop_r) begin
              state <= ST_POP_WR;
            end else begin
              state <= ST_IDLE;
              done  <= 1'b1;
            end
          end else if (status.scan_last) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        ST_POP_WR: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/circular_bucket_priority_queue_top_tb.sv
// ----------------------------------------------------------------------------
// circular_bucket_priority_queue_top_tb
// Self-checking bench for the circular bucket queue: a clocked driver issues
// command beats from a backlog, a shadow model of the bucket lists predicts
// each reply beat, and a clocked monitor compares every done beat in order.
// ----------------------------------------------------------------------------
module circular_bucket_priority_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbpq_pkg::*;

  localparam int NUM_BUCKETS = 256;
  localparam int NUM_ELEMS   = 4096;
  localparam int LINK_W      = 13;
  localparam logic [LINK_W-1:0] NULL_LINK = 13'd4096;

  // Codes the block must ignore.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  // Longest legal quiet stretch is a full memory sweep (reset or clear) plus
  // a sender gap, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_PHASES  = 20;
  localparam int PHASE_ITEMS    = 100;
  localparam int SETTLE_CYCLES  = 300;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ELEM_W-1:0] elem;
    logic [BKT_W-1:0]  bkt;
    logic [BKT_W-1:0]  to_bkt;
  } queue_cmd_t;

  typedef struct packed {
    logic [ELEM_W-1:0] elem;
    logic              hit;
    logic              empty;
  } queue_reply_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_we    = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              start     = 1'b0;
  logic [OP_W-1:0]   operation = '0;
  logic [ELEM_W-1:0] elem      = '0;
  logic [BKT_W-1:0]  bucket    = '0;
  logic [BKT_W-1:0]  to_bucket = '0;
  logic              busy;
  logic              done;
  logic [ELEM_W-1:0] popped_elem;
  logic              found;
  logic              is_empty;

  circular_bucket_priority_queue_top #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .NUM_ELEMS   (NUM_ELEMS)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .elem        (elem),
    .bucket      (bucket),
    .to_bucket   (to_bucket),
    .done        (done),
    .popped_elem (popped_elem),
    .found       (found),
    .is_empty    (is_empty)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow model of the queue. These tables mirror the block's link memories
  // and are only touched when a command beat is accepted, so they always
  // describe the state the block should have after the accepted beats.
  // --------------------------------------------------------------------------
  logic [LINK_W-1:0] bkt_head [NUM_BUCKETS];
  logic [LINK_W-1:0] bkt_tail [NUM_BUCKETS];
  logic [LINK_W-1:0] nxt_link [NUM_ELEMS];
  logic [LINK_W-1:0] prv_link [NUM_ELEMS];
  int                cur_bkt;
  int                active_buckets;

  queue_cmd_t   cmd_backlog[$];
  queue_reply_t predicted_replies[$];
  queue_cmd_t   issued_cmd;
  int           items_issued   = 0;
  int           results_seen   = 0;
  int           fault_count    = 0;
  int           sender_gap_max = 0;
  int           gap_left       = 0;
  int           stall_cycles   = 0;
  bit           cmd_taken;

  // Stimulus-side view of which bucket each element sits in (-1 if none).
  // It drifts as pops remove elements it cannot see, and is rebuilt from
  // the shadow tables at the start of every phase while the block is idle.
  int gen_bkt [NUM_ELEMS];
  int gen_members[$];

  function automatic void wipe_tables();
    foreach (bkt_head[i]) begin
      bkt_head[i] = NULL_LINK;
      bkt_tail[i] = NULL_LINK;
    end
    foreach (nxt_link[i]) begin
      nxt_link[i] = NULL_LINK;
      prv_link[i] = NULL_LINK;
    end
    cur_bkt = 0;
  endfunction

  // Append to the tail of a bucket. An element that is already queued is
  // simply relinked, exactly as the pointer writes fall.
  function automatic void link_tail(int b, logic [ELEM_W-1:0] e);
    logic [LINK_W-1:0] t;
    t = bkt_tail[b];
    if (bkt_head[b] == NULL_LINK || t == NULL_LINK) begin
      bkt_head[b] = {1'b0, e};
      prv_link[e] = NULL_LINK;
    end else begin
      nxt_link[t[ELEM_W-1:0]] = {1'b0, e};
      prv_link[e] = t;
    end
    bkt_tail[b] = {1'b0, e};
    nxt_link[e] = NULL_LINK;
  endfunction

  // Unlink from a named bucket. An element that is neither that bucket's
  // head nor has a predecessor is left alone; stale links stay in place.
  function automatic void unlink(int b, logic [ELEM_W-1:0] e);
    logic [LINK_W-1:0] p;
    logic [LINK_W-1:0] n;
    p = prv_link[e];
    n = nxt_link[e];
    if (bkt_head[b] == {1'b0, e}) begin
      bkt_head[b] = n;
      if (n == NULL_LINK) bkt_tail[b] = NULL_LINK;
      else prv_link[n[ELEM_W-1:0]] = NULL_LINK;
    end else if (p != NULL_LINK) begin
      nxt_link[p[ELEM_W-1:0]] = n;
      if (n == NULL_LINK) bkt_tail[b] = p;
      else prv_link[n[ELEM_W-1:0]] = p;
    end
  endfunction

  // Circular scan from the current bucket to the first non-empty one. A
  // current bucket left outside a shrunken scan range restarts at zero.
  function automatic bit seek_nonempty();
    int first;
    if (cur_bkt >= active_buckets) cur_bkt = 0;
    if (bkt_head[cur_bkt] != NULL_LINK) return 1'b1;
    first = cur_bkt;
    cur_bkt = (cur_bkt + 1) % active_buckets;
    while (bkt_head[cur_bkt] == NULL_LINK && cur_bkt != first)
      cur_bkt = (cur_bkt + 1) % active_buckets;
    return bkt_head[cur_bkt] != NULL_LINK;
  endfunction

  // Apply one command to the shadow model and return the reply it must give.
  function automatic queue_reply_t apply_queue_op(queue_cmd_t c);
    queue_reply_t      r;
    logic [LINK_W-1:0] h;
    logic [LINK_W-1:0] n;
    r = '0;
    case (c.op)
      OP_INSERT: begin
        if (c.bkt < active_buckets) link_tail(c.bkt, c.elem);
      end
      OP_POP: begin
        if (seek_nonempty()) begin
          h = bkt_head[cur_bkt];
          n = nxt_link[h[ELEM_W-1:0]];
          if (n == NULL_LINK) begin
            bkt_head[cur_bkt] = NULL_LINK;
            bkt_tail[cur_bkt] = NULL_LINK;
          end else begin
            bkt_head[cur_bkt] = n;
            prv_link[n[ELEM_W-1:0]] = NULL_LINK;
          end
          r.elem = h[ELEM_W-1:0];
          r.hit  = 1'b1;
        end
      end
      OP_REMOVE: unlink(c.bkt, c.elem);
      OP_MOVE: begin
        if (c.to_bkt < active_buckets) begin
          unlink(c.bkt, c.elem);
          link_tail(c.to_bkt, c.elem);
        end
      end
      OP_ISEMPTY: r.empty = !seek_nonempty();
      OP_CLEAR:   wipe_tables();
      default: ;
    endcase
    return r;
  endfunction

  task automatic log_fault(input string what);
    if (fault_count < 10) $display("%s", what);
    fault_count++;
  endtask

  // --------------------------------------------------------------------------
  // Driver. A beat is taken on the edge where start is high and busy is low;
  // the shadow model is advanced right there. Each beat then draws a gap of
  // zero up to sender_gap_max before the next one is offered, and with
  // a zero gap start simply stays high with the next beat's fields.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      gap_left =  0;
    end else begin
      cmd_taken = start && !busy;
      if (cmd_taken) begin
        predicted_replies.push_back(apply_queue_op(issued_cmd));
        gap_left = $urandom_range(0, sender_gap_max);
      end
      if (cmd_taken || !start) begin
        if (gap_left == 0 && cmd_backlog.size() != 0) begin
          issued_cmd = cmd_backlog.pop_front();
          operation <= issued_cmd.op;
          elem      <= issued_cmd.elem;
          bucket    <= issued_cmd.bkt;
          to_bucket <= issued_cmd.to_bkt;
          start     <= 1'b1;
        end else begin
          if (!cmd_taken && gap_left > 0) gap_left--;
          start <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. A done beat lasts one cycle and cannot be held off, so every
  // edge with done high is checked against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    queue_reply_t want;
    if (!rst && done) begin
      results_seen++;
      if (predicted_replies.size() == 0) begin
        log_fault($sformatf("unexpected reply beat: elem=%0d found=%0b empty=%0b",
                            popped_elem, found, is_empty));
      end else begin
        want = predicted_replies.pop_front();
        if (popped_elem !== want.elem || found !== want.hit || is_empty !== want.empty)
          log_fault($sformatf({"reply mismatch: expected elem=%0d found=%0b empty=%0b,",
                               " got elem=%0d found=%0b empty=%0b"},
                              want.elem, want.hit, want.empty,
                              popped_elem, found, is_empty));
      end
    end
  end

  // Watchdog: any stretch this long with no beat moving either way is a hang.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic push_cmd(input logic [OP_W-1:0] op, input int e, input int b,
                          input int tb);
    queue_cmd_t c;
    c.op     = op;
    c.elem   = e[ELEM_W-1:0];
    c.bkt    = b[BKT_W-1:0];
    c.to_bkt = tb[BKT_W-1:0];
    cmd_backlog.push_back(c);
    items_issued++;
  endtask

  function automatic void gen_note(int e, int b);
    if (gen_bkt[e] < 0) gen_members.push_back(e);
    gen_bkt[e] = b;
  endfunction

  function automatic void gen_forget(int e);
    if (gen_bkt[e] >= 0) begin
      foreach (gen_members[i]) begin
        if (gen_members[i] == e) begin
          gen_members.delete(i);
          break;
        end
      end
      gen_bkt[e] = -1;
    end
  endfunction

  function automatic void gen_reset_view();
    gen_members.delete();
    foreach (gen_bkt[i]) gen_bkt[i] = -1;
  endfunction

  // Rebuild the stimulus view from the shadow lists. Relinking an element
  // that was already queued can leave loops, so each walk is bounded.
  function automatic void gen_resync();
    logic [LINK_W-1:0] p;
    int                steps;
    gen_reset_view();
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      p = bkt_head[b];
      steps = 0;
      while (p != NULL_LINK && steps < NUM_ELEMS) begin
        gen_note(p[ELEM_W-1:0], b);
        p = nxt_link[p[ELEM_W-1:0]];
        steps++;
      end
    end
  endfunction

  // Mostly in-range buckets; now and then any 8-bit value, which can be out of
  // range whenever the scan has been shortened.
  function automatic int pick_bucket();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, NUM_BUCKETS - 1);
    return $urandom_range(0, active_buckets - 1);
  endfunction

  // Build one random command. Most are well-formed: inserts of elements not
  // yet queued, and removes and moves of elements that really sit in the
  // named bucket. The rest are misdirected or plain random beats.
  task automatic queue_random_cmd();
    queue_cmd_t c;
    int         roll;
    int         e;
    int         tries;
    c    = queue_cmd_t'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      tries = 0;
      do begin
        e = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NUM_ELEMS - 1)
                                        : $urandom_range(0, 511);
        tries++;
      end while (gen_bkt[e] >= 0 && tries < 3);
      c.op   = OP_INSERT;
      c.elem = ELEM_W'(e);
      c.bkt  = BKT_W'(pick_bucket());
      if (c.bkt < active_buckets) gen_note(e, c.bkt);
    end else if (roll < 55) begin
      c.op = OP_POP;
    end else if (roll < 85) begin
      c.op = (roll < 70) ? OP_REMOVE : OP_MOVE;
      if (gen_members.size() != 0 && $urandom_range(0, 99) < 85) begin
        e      = gen_members[$urandom_range(0, gen_members.size() - 1)];
        c.elem = ELEM_W'(e);
        c.bkt  = BKT_W'(gen_bkt[e]);
      end
      if (c.op == OP_MOVE) begin
        c.to_bkt = BKT_W'(pick_bucket());
        if (c.to_bkt < active_buckets) begin
          gen_forget(c.elem);
          gen_note(c.elem, c.to_bkt);
        end
      end else begin
        if (gen_bkt[c.elem] == c.bkt) gen_forget(c.elem);
      end
    end else if (roll < 93) begin
      c.op = OP_ISEMPTY;
    end else if (roll < 94) begin
      c.op = OP_CLEAR;
      gen_reset_view();
    end else if (roll < 96) begin
      c.op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
    end
    // From 96 up the beat stays fully random, operation included.
    push_cmd(c.op, c.elem, c.bkt, c.to_bkt);
  endtask

  // Every command gives exactly one reply, so the block is idle once the
  // reply count has caught up and busy is low.
  task automatic wait_for_drain();
    while (results_seen < items_issued || busy) @(posedge clk);
  endtask

  // Only called while idle. The shadow model takes the same clamp the block
  // applies: zero acts as one bucket, anything too large as all of them.
  task automatic set_bucket_count(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (v == 0) active_buckets = 1;
    else if (v > NUM_BUCKETS) active_buckets = NUM_BUCKETS;
    else active_buckets = int'(v);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    logic [CFG_W-1:0] fixed_counts [8];
    logic [CFG_W-1:0] count_val;

    fixed_counts = '{9'd0, 9'd1, 9'd2, 9'd511, 9'd257, 9'd256, 9'd3, 9'd16};
    wipe_tables();
    active_buckets = NUM_BUCKETS;
    gen_reset_view();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset bucket count. The driver waits for busy to
    // drop, so these beats also sit out the power-up sweep.
    sender_gap_max = 12;
    push_cmd(OP_ISEMPTY, 0, 0, 0);          // empty queue: full circle scan
    push_cmd(OP_POP, 4095, 255, 255);       // pop on an empty queue
    push_cmd(OP_INSERT, 4095, 255, 0);      // largest element, last bucket
    push_cmd(OP_INSERT, 0, 0, 0);
    push_cmd(OP_INSERT, 1, 0, 0);
    push_cmd(OP_INSERT, 2, 0, 0);
    push_cmd(OP_POP, 0, 0, 0);              // FIFO order inside a bucket
    push_cmd(OP_REMOVE, 2, 0, 0);           // remove the tail
    push_cmd(OP_REMOVE, 7, 3, 0);           // element that is not linked
    push_cmd(OP_MOVE, 1, 0, 200);
    push_cmd(OP_ISEMPTY, 0, 0, 0);          // advances current bucket to 200
    push_cmd(OP_POP, 0, 0, 0);
    push_cmd(OP_POP, 0, 0, 0);              // finds bucket 255
    push_cmd(OP_POP, 0, 0, 0);              // wraps all the way round, empty
    push_cmd(OP_INSERT, 10, 5, 0);
    push_cmd(OP_INSERT, 10, 5, 0);          // insert of an element already queued
    push_cmd(OP_REMOVE, 10, 6, 0);          // remove from the wrong bucket
    push_cmd(OP_INSERT, 4095, 255, 0);
    push_cmd(OP_REMOVE, 4095, 255, 0);      // remove the head
    push_cmd(OP_SPARE_LO, 4095, 255, 255);  // unused codes do nothing
    push_cmd(OP_SPARE_HI, 4095, 255, 255);
    push_cmd(OP_CLEAR, 4095, 255, 255);
    push_cmd(OP_INSERT, 'hAAA, 250, 'h55);
    push_cmd(OP_ISEMPTY, 'h555, 'hAA, 0);   // leaves current bucket at 250
    push_cmd(OP_MOVE, 'hAAA, 250, 255);
    wait_for_drain();

    // Random phases, each at its own bucket count. The first few hit the
    // extremes of the register, including values it must clamp; shrinking
    // right after the directed part leaves the current bucket out of range.
    // Each phase drains fully, which also gives the sender a long pause.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph < 8) count_val = fixed_counts[ph];
      else if ($urandom_range(0, 1)) count_val = CFG_W'($urandom_range(1, 32));
      else count_val = CFG_W'($urandom_range(0, 511));
      set_bucket_count(count_val);
      sender_gap_max = 12;
      gen_resync();
      repeat (PHASE_ITEMS) queue_random_cmd();
      wait_for_drain();
    end

    // Give any stray reply time to show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (predicted_replies.size() != 0)
      log_fault($sformatf("%0d predicted replies never arrived",
                          predicted_replies.size()));

    if (fault_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
